// ===== rtl/core/two_joint_servo_ramp_macros.svh =====
// assertion macros for the two joint servo ramp
// used by the rtl files that carry concurrent assertions, expects clk and rst in scope
`ifndef TWO_JOINT_SERVO_RAMP_MACROS_SVH
`define TWO_JOINT_SERVO_RAMP_MACROS_SVH
`ifndef SYNTH
`define TJSR_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tjsr assertion failed");
`define TJSR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tjsr assertion failed");
`else
`define TJSR_ASSERT_IMP(lbl, pre, post)
`define TJSR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/tjsr_pkg.sv =====
// shared types, constants and clamp functions of the two joint servo ramp
// no dependencies
package tjsr_pkg;

  localparam int ANGLE_W    = 8;
  localparam int TGT_W      = 10;
  localparam int DUR_W      = 24;
  localparam int PULSE_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_BASE = 3'd5;

  // reset values
  localparam logic [ANGLE_W-1:0] RST_FIRST_MIN  = 8'd10;
  localparam logic [ANGLE_W-1:0] RST_FIRST_MAX  = 8'd155;
  localparam logic [ANGLE_W-1:0] RST_SECOND_MIN = 8'd10;
  localparam logic [ANGLE_W-1:0] RST_SECOND_MAX = 8'd180;
  localparam logic [DUR_W-1:0]   RST_MIN_STEP   = 24'd5000;
  localparam logic [ANGLE_W-1:0] RST_PULSE_BASE = 8'd55;
  localparam logic [ANGLE_W-1:0] FIRST_REST     = 8'd100;
  localparam logic [ANGLE_W-1:0] SECOND_REST    = 8'd105;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DIV,
    ST_INTERVAL,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic capture_move;
    logic count_dec;
    logic halt;
    logic div_load;
    logic div_step;
    logic load_interval;
    logic do_step;
  } dp_cmd_t;

  typedef struct packed {
    logic moving;
    logic count_gt1;
    logic dist_zero;
    logic div_last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [ANGLE_W-1:0] clamp_target(
    input logic signed [TGT_W-1:0] v,
    input logic [ANGLE_W-1:0]      lo,
    input logic [ANGLE_W-1:0]      hi
  );
    logic signed [TGT_W:0] vx;
    logic signed [TGT_W:0] lo_s;
    logic signed [TGT_W:0] hi_s;
    vx   = (TGT_W+1)'(v);
    lo_s = $signed({{(TGT_W+1-ANGLE_W){1'b0}}, lo});
    hi_s = $signed({{(TGT_W+1-ANGLE_W){1'b0}}, hi});
    if (vx < lo_s) vx = lo_s;
    if (vx > hi_s) vx = hi_s;
    return vx[ANGLE_W-1:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] clamp_angle(
    input logic [ANGLE_W-1:0] v,
    input logic [ANGLE_W-1:0] lo,
    input logic [ANGLE_W-1:0] hi
  );
    logic [ANGLE_W-1:0] r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/core/tjsr_ctrl.sv =====
// controller state machine of the two joint servo ramp
// depends on tjsr_pkg, drives the datapath through command and status structs
module tjsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  tjsr_pkg::dp_status_t status,
  output tjsr_pkg::dp_cmd_t    cmd
);
  import tjsr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_MOVE) begin
            state_next = ST_DIST;
          end else if (status.moving && !status.count_gt1) begin
            state_next = ST_STEP;
          end
        end
      end
      ST_DIST: begin
        state_next = status.dist_zero ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_INTERVAL;
      end
      ST_INTERVAL: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture_move = (operation == OP_MOVE);
          cmd.count_dec    = (operation == OP_TICK) && status.moving && status.count_gt1;
        end
      end
      ST_DIST: begin
        cmd.halt     = status.dist_zero;
        cmd.div_load = !status.dist_zero;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_INTERVAL: begin
        cmd.load_interval = 1'b1;
      end
      ST_STEP: begin
        cmd.do_step = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/tjsr_dp.sv =====
// datapath of the two joint servo ramp: registers, clamp, serial divider, step, result buffer
// depends on tjsr_pkg and two_joint_servo_ramp_macros.svh
`include "two_joint_servo_ramp_macros.svh"
module tjsr_dp #(
  parameter int TIME_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [tjsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tjsr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [tjsr_pkg::TGT_W-1:0]   target_first,
  input  logic signed [tjsr_pkg::TGT_W-1:0]   target_second,
  input  logic [tjsr_pkg::DUR_W-1:0]          duration_us,
  input  tjsr_pkg::dp_cmd_t                   cmd,
  output tjsr_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                joint_index,
  output logic [tjsr_pkg::PULSE_W-1:0]        servo_pulse,
  output logic [tjsr_pkg::ANGLE_W-1:0]        angle,
  output logic                                last
);
  import tjsr_pkg::*;

  localparam int EXT_W = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;
  localparam int CNT_W = $clog2(DUR_W + 1);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DUR_W);

  // configuration registers
  logic [ANGLE_W-1:0] first_min;
  logic [ANGLE_W-1:0] first_max;
  logic [ANGLE_W-1:0] second_min;
  logic [ANGLE_W-1:0] second_max;
  logic [DUR_W-1:0]   min_step;
  logic [ANGLE_W-1:0] pulse_base;

  // ramp state
  logic [ANGLE_W-1:0]    first_angle;
  logic [ANGLE_W-1:0]    second_angle;
  logic [ANGLE_W-1:0]    first_goal;
  logic [ANGLE_W-1:0]    second_goal;
  logic [TIME_WIDTH-1:0] step_interval;
  logic [TIME_WIDTH-1:0] countdown;
  logic                  moving;

  // divider
  logic [DUR_W-1:0]   duration;
  logic [DUR_W-1:0]   quo;
  logic [ANGLE_W-1:0] rem;
  logic [ANGLE_W-1:0] divisor;
  logic [CNT_W-1:0]   div_cnt;

  // result buffer, entry 0 is the head
  logic [1:0]         res_valid;
  logic [1:0]         res_joint;
  logic [PULSE_W-1:0] res_pulse [2];
  logic [ANGLE_W-1:0] res_angle [2];
  logic [1:0]         res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_min  <= RST_FIRST_MIN;
      first_max  <= RST_FIRST_MAX;
      second_min <= RST_SECOND_MIN;
      second_max <= RST_SECOND_MAX;
      min_step   <= RST_MIN_STEP;
      pulse_base <= RST_PULSE_BASE;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_FIRST_MIN:  first_min  <= cfg_data[ANGLE_W-1:0];
        REG_FIRST_MAX:  first_max  <= cfg_data[ANGLE_W-1:0];
        REG_SECOND_MIN: second_min <= cfg_data[ANGLE_W-1:0];
        REG_SECOND_MAX: second_max <= cfg_data[ANGLE_W-1:0];
        REG_MIN_STEP:   min_step   <= cfg_data[DUR_W-1:0];
        REG_PULSE_BASE: pulse_base <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // joint distance of the new goals
  logic [ANGLE_W-1:0] dist_first;
  logic [ANGLE_W-1:0] dist_second;
  logic [ANGLE_W-1:0] max_dist;

  always_comb begin
    dist_first  = (first_goal >= first_angle) ? first_goal - first_angle
                                              : first_angle - first_goal;
    dist_second = (second_goal >= second_angle) ? second_goal - second_angle
                                                : second_angle - second_goal;
    max_dist    = (dist_first > dist_second) ? dist_first : dist_second;
  end

  // one restoring division step
  logic [ANGLE_W:0]   shifted;
  logic               q_bit;
  logic [ANGLE_W:0]   diff;

  always_comb begin
    shifted = {rem, quo[DUR_W-1]};
    diff    = shifted - {1'b0, divisor};
    q_bit   = (shifted >= {1'b0, divisor});
  end

  logic [DUR_W-1:0] interval_raw;
  logic [EXT_W-1:0] interval_ext;

  always_comb begin
    interval_raw = (quo < min_step) ? min_step : quo;
    interval_ext = EXT_W'(interval_raw);
  end

  // one ramp step for both joints
  logic               first_moves;
  logic               second_moves;
  logic [ANGLE_W-1:0] first_next;
  logic [ANGLE_W-1:0] second_next;
  logic [PULSE_W-1:0] first_pulse;
  logic [PULSE_W-1:0] second_pulse;

  always_comb begin
    first_moves  = (first_angle != first_goal);
    second_moves = (second_angle != second_goal);
    first_next   = clamp_angle((first_goal > first_angle) ? first_angle + 1'b1
                                                          : first_angle - 1'b1,
                               first_min, first_max);
    second_next  = clamp_angle((second_goal > second_angle) ? second_angle + 1'b1
                                                            : second_angle - 1'b1,
                               second_min, second_max);
    first_pulse  = {1'b0, pulse_base} + {1'b0, first_next};
    second_pulse = {1'b0, pulse_base} + {1'b0, second_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_angle   <= FIRST_REST;
      second_angle  <= SECOND_REST;
      first_goal    <= FIRST_REST;
      second_goal   <= SECOND_REST;
      step_interval <= '0;
      countdown     <= '0;
      moving        <= 1'b0;
    end else begin
      if (cmd.capture_move) begin
        first_goal  <= clamp_target(target_first, first_min, first_max);
        second_goal <= clamp_target(target_second, second_min, second_max);
      end
      if (cmd.count_dec) begin
        countdown <= countdown - 1'b1;
      end
      if (cmd.halt) begin
        moving    <= 1'b0;
        countdown <= '0;
      end
      if (cmd.load_interval) begin
        step_interval <= interval_ext[TIME_WIDTH-1:0];
      end
      if (cmd.do_step) begin
        if (first_moves) first_angle <= first_next;
        if (second_moves) second_angle <= second_next;
        moving    <= (first_moves  && (first_next  != first_goal)) ||
                     (second_moves && (second_next != second_goal));
        countdown <= step_interval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= DIV_STEPS;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_move) begin
      duration <= duration_us;
    end
    if (cmd.div_load) begin
      quo     <= duration;
      rem     <= '0;
      divisor <= max_dist;
    end else if (cmd.div_step) begin
      quo <= {quo[DUR_W-2:0], q_bit};
      rem <= q_bit ? diff[ANGLE_W-1:0] : shifted[ANGLE_W-1:0];
    end
  end

  // result buffer: loaded only when empty, drained one result per handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= '0;
    end else if (cmd.do_step) begin
      res_valid <= {first_moves && second_moves, first_moves || second_moves};
    end else if (out_valid && out_ready) begin
      res_valid <= {1'b0, res_valid[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_step) begin
      res_joint[0]    <= !first_moves;
      res_pulse[0]    <= first_moves ? first_pulse : second_pulse;
      res_angle[0]    <= first_moves ? first_next : second_next;
      res_last[0]     <= !(first_moves && second_moves);
      res_joint[1]    <= 1'b1;
      res_pulse[1]    <= second_pulse;
      res_angle[1]    <= second_next;
      res_last[1]     <= 1'b1;
    end else if (out_valid && out_ready) begin
      res_joint[0] <= res_joint[1];
      res_pulse[0] <= res_pulse[1];
      res_angle[0] <= res_angle[1];
      res_last[0]  <= res_last[1];
    end
  end

  assign out_valid   = res_valid[0];
  assign joint_index = res_joint[0];
  assign servo_pulse = res_pulse[0];
  assign angle       = res_angle[0];
  assign last        = res_last[0];

  assign status.moving    = moving;
  assign status.count_gt1 = (countdown > TIME_WIDTH'(1));
  assign status.dist_zero = (max_dist == '0);
  assign status.div_last  = (div_cnt == CNT_W'(1));
  assign status.out_busy  = res_valid[0];

  `TJSR_ASSERT_IMP(a_buf_order, res_valid[1], res_valid[0])
  `TJSR_ASSERT_IMP(a_head_last, res_valid[0] && !res_valid[1], res_last[0])
  `TJSR_ASSERT_IMP(a_step_empty, cmd.do_step, !res_valid[0] && (first_moves || second_moves))
  `TJSR_ASSERT_IMP(a_div_rem, cmd.div_step, rem < divisor)

endmodule

// ===== rtl/core/two_joint_servo_ramp.sv =====
// top level of the two joint servo ramp
// depends on tjsr_pkg, tjsr_ctrl and tjsr_dp
//
// Ramps two servo joints one degree per step toward clamped goal angles. A
// tick transaction counts the interval down while the ramp moves, and steps
// when it ends an interval. A move transaction is accepted and clamped, then
// the larger joint distance is found (a zero distance halts the ramp), then
// the bit-serial divider forms duration / distance, one quotient bit a
// cycle, then the interval is floored and the joints step. A step waits
// until the one or two results of the previous step have left the
// two-entry result buffer; results leave in joint order, first joint first,
// with last set on the final one of the transaction.
module two_joint_servo_ramp #(
  parameter int TIME_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_wen,
  input  logic [tjsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tjsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic signed [tjsr_pkg::TGT_W-1:0] target_first,
  input  logic signed [tjsr_pkg::TGT_W-1:0] target_second,
  input  logic [tjsr_pkg::DUR_W-1:0]        duration_us,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              joint_index,
  output logic [tjsr_pkg::PULSE_W-1:0]      servo_pulse,
  output logic [tjsr_pkg::ANGLE_W-1:0]      angle,
  output logic                              last
);
  import tjsr_pkg::*;

  // command and status between the sequencer and the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: accepts a transaction only when idle
  tjsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: registers, clamp, divider, step logic and result buffer
  tjsr_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .target_first  (target_first),
    .target_second (target_second),
    .duration_us   (duration_us),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .joint_index   (joint_index),
    .servo_pulse   (servo_pulse),
    .angle         (angle),
    .last          (last)
  );

endmodule
